/* rtl/core/lmfsd_pkg.sv */
// ----------------------------------------------------------------------------
// LED matrix frame scan driver package
// Shared types and fixed constants of the row scan driver.
// ----------------------------------------------------------------------------
package lmfsd_pkg;

    // Bits shifted out to the column and row chains for one row.
    localparam int unsigned BITS_PER_ROW = 16;
    localparam int unsigned BIT_W        = 4;
    localparam int unsigned PLANE_W      = 16;
    localparam int unsigned BYTE_W       = 8;

    // Values held by the display registers straight after reset.
    localparam logic [PLANE_W-1:0] PLANE_ONE_ROW0_RST = 16'h8000;
    localparam logic [BYTE_W-1:0]  DUTY_RST           = 8'hFF;

    // Input command codes.
    localparam logic CMD_RX_BYTE  = 1'b0;
    localparam logic CMD_ROW_SCAN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_FETCH,
        ST_SHIFT
    } lmfsd_state_t;

endpackage

/* rtl/core/lmfsd_in_if.sv */
// ----------------------------------------------------------------------------
// LED matrix driver input channel
// Valid/ready channel carrying one command and its received byte.
// ----------------------------------------------------------------------------
interface lmfsd_in_if;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);

endinterface

/* rtl/core/lmfsd_out_if.sv */
// ----------------------------------------------------------------------------
// LED matrix driver output channel
// Valid/ready channel carrying one serial clock of shift chain data.
// ----------------------------------------------------------------------------
interface lmfsd_out_if;

    logic       valid;
    logic       ready;
    logic       row_bit;
    logic       col1_bit;
    logic       col2_bit;
    logic       latch;
    logic [7:0] brightness;

    modport source (output valid, output row_bit, output col1_bit, output col2_bit,
                    output latch, output brightness, input ready);
    modport sink   (input valid, input row_bit, input col1_bit, input col2_bit,
                    input latch, input brightness, output ready);

endinterface

/* rtl/core/led_matrix_frame_scan_driver_top.sv */
// A received byte produces no output transaction. A row scan fetches the row,
// then makes 16 output transactions, one per cycle when the sink is ready; the
// block is ready again once the last of them is taken.
// At the top row with a frame pending, a commit sweep runs first, one staging
// byte a cycle through the single read port.
// Reset is asynchronous and active low; the block comes out of reset ready.
// ----------------------------------------------------------------------------
// LED matrix frame scan driver
// Collects a staging frame from received bytes and, on each row scan command,
// serialises the row select word and the two column plane words.
// ----------------------------------------------------------------------------
module led_matrix_frame_scan_driver_top #(
    parameter int unsigned ROWS        = 16,
    parameter int unsigned FRAME_BYTES = 65
) (
    input  logic   clk,
    input  logic   rst_n,
    lmfsd_in_if.sink    scan_in,
    lmfsd_out_if.source scan_out
);
    import lmfsd_pkg::*;

    // Widths that follow from the frame and matrix size.
    localparam int unsigned RW         = $clog2(ROWS);
    localparam int unsigned SW         = $clog2(FRAME_BYTES);
    localparam int unsigned LAYOUT_LEN = 4 * ROWS + 1;
    localparam int unsigned CW         = $clog2(LAYOUT_LEN + 1);

    // ------------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------------
    // The staging frame is a plain memory with no reset: the first full frame
    // always writes every entry before a commit can read it. The two plane
    // memories each carry a valid bit per row, so a row that has never been
    // committed reads back as its reset value.
    logic [BYTE_W-1:0]  stg_mem [FRAME_BYTES];
    logic [BYTE_W-1:0]  stg_rd_reg;
    logic [PLANE_W-1:0] p1_mem [ROWS];
    logic [PLANE_W-1:0] p2_mem [ROWS];
    logic [PLANE_W-1:0] p1_rd_reg;
    logic [PLANE_W-1:0] p2_rd_reg;

    // ------------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------------
    lmfsd_state_t      state_reg, state_next;
    logic [SW-1:0]     fill_reg;
    logic              pend_reg;
    logic [RW-1:0]     row_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [CW-1:0]     cnt_reg;
    logic [BYTE_W-1:0] hi_reg;
    logic [BYTE_W-1:0] duty_reg;
    logic [ROWS-1:0]   valid1_reg;
    logic [ROWS-1:0]   valid2_reg;

    logic in_acc;
    logic out_acc;
    logic last_bit;
    logic commit_done;

    // Commit sweep decode.
    int unsigned       b_idx;
    logic [BYTE_W-1:0] cm_byte;
    logic              cm_live;
    logic              cm_p1;
    logic              cm_p2;
    logic              cm_duty;
    logic              cm_odd;
    logic [RW-1:0]     cm_row;
    logic [SW-1:0]     stg_addr;

    // Current row words after the reset-value substitution.
    logic [PLANE_W-1:0] word1;
    logic [PLANE_W-1:0] word2;

    assign in_acc      = scan_in.valid && scan_in.ready;
    assign out_acc     = scan_out.valid && scan_out.ready;
    assign last_bit    = (bit_reg == BIT_W'(BITS_PER_ROW - 1));
    assign commit_done = (cnt_reg == CW'(LAYOUT_LEN));

    // ------------------------------------------------------------------------
    // Commit sweep
    // ------------------------------------------------------------------------
    // The counter issues staging read addresses 0 .. 4*ROWS; the staging read
    // data is registered, so the byte being placed is cnt_reg - 1.
    // Plane one takes bytes 0 .. 2*ROWS-1, plane two the next 2*ROWS, and the
    // final byte becomes the brightness duty. Each word is big-endian: the
    // even byte is held in hi_reg and the odd byte completes the write.
    // Layout bytes that fall beyond a small frame read as zero.
    always_comb
    begin
        b_idx    = 32'(cnt_reg) - 32'd1;
        cm_live  = (state_reg == ST_COMMIT) && (cnt_reg != '0);
        cm_byte  = (b_idx < FRAME_BYTES) ? stg_rd_reg : '0;
        cm_p1    = cm_live && (b_idx < 2 * ROWS);
        cm_p2    = cm_live && (b_idx >= 2 * ROWS) && (b_idx < 4 * ROWS);
        cm_duty  = cm_live && (b_idx == 4 * ROWS);
        cm_odd   = b_idx[0];
        cm_row   = cm_p1 ? RW'(b_idx >> 1) : RW'((b_idx - 2 * ROWS) >> 1);
        stg_addr = ((state_reg == ST_COMMIT) && (32'(cnt_reg) < FRAME_BYTES))
                   ? SW'(cnt_reg) : '0;
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc && (scan_in.command == CMD_RX_BYTE))
        begin
            stg_mem[fill_reg] <= scan_in.rx_byte;
        end
        stg_rd_reg <= stg_mem[stg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_p1 && cm_odd)
        begin
            p1_mem[cm_row] <= {hi_reg, cm_byte};
        end
        if (cm_p2 && cm_odd)
        begin
            p2_mem[cm_row] <= {hi_reg, cm_byte};
        end
        p1_rd_reg <= p1_mem[row_reg];
        p2_rd_reg <= p2_mem[row_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cm_live && !cm_odd)
        begin
            hi_reg <= cm_byte;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (scan_in.command == CMD_ROW_SCAN))
                begin
                    if ((row_reg == RW'(ROWS - 1)) && pend_reg)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (commit_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (out_acc && last_bit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    // The row select word is one-hot on the row index, so its bit k is set
    // exactly when the row equals k; rows above the chain never match.
    always_comb
    begin
        word1 = valid1_reg[row_reg] ? p1_rd_reg
              : ((row_reg == '0) ? PLANE_ONE_ROW0_RST : '0);
        word2 = valid2_reg[row_reg] ? p2_rd_reg : '0;

        scan_in.ready       = (state_reg == ST_IDLE);
        scan_out.valid      = (state_reg == ST_SHIFT);
        scan_out.row_bit    = (32'(row_reg) == 32'(bit_reg));
        scan_out.col1_bit   = word1[bit_reg];
        scan_out.col2_bit   = word2[bit_reg];
        scan_out.latch      = last_bit;
        scan_out.brightness = duty_reg;
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            row_reg    <= RW'(ROWS - 1);
            bit_reg    <= '0;
            cnt_reg    <= '0;
            duty_reg   <= DUTY_RST;
            valid1_reg <= '0;
            valid2_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Receive path: the fill count wraps when the frame is complete.
            if (in_acc && (scan_in.command == CMD_RX_BYTE))
            begin
                if (fill_reg == SW'(FRAME_BYTES - 1))
                begin
                    fill_reg <= '0;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= fill_reg + SW'(1);
                end
            end

            // A commit consumes the pending frame as it starts.
            if ((state_reg == ST_IDLE) && (state_next == ST_COMMIT))
            begin
                pend_reg <= 1'b0;
            end

            if (state_reg == ST_COMMIT)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (cm_p1 && cm_odd)
            begin
                valid1_reg[cm_row] <= 1'b1;
            end
            if (cm_p2 && cm_odd)
            begin
                valid2_reg[cm_row] <= 1'b1;
            end
            if (cm_duty)
            begin
                duty_reg <= cm_byte;
            end

            // Serial bit counter and row count-down with wrap.
            if (out_acc)
            begin
                bit_reg <= bit_reg + BIT_W'(1);
                if (last_bit)
                begin
                    row_reg <= (row_reg == '0) ? RW'(ROWS - 1) : row_reg - RW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The input side is held off while a row is being shifted out.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.valid |-> !scan_in.ready)
    else $error("input accepted while a row is being shifted");

    // Once the latch transaction completes, the block is ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_out.valid && scan_out.ready && scan_out.latch) |=> scan_in.ready)
    else $error("block not ready after the latch transaction");

    // A frame is only committed at the start of a pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> (row_reg == RW'(ROWS - 1)))
    else $error("commit outside the top row");

    // The pending frame is consumed when the commit sweep starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_COMMIT) |-> !pend_reg)
    else $error("frame still pending during commit");

    // The bit counter sits at zero whenever a row scan begins.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (bit_reg == '0))
    else $error("row shift does not start at the first bit");

endmodule
